>>> hw/rtl/gwrm_pkg.sv
package gwrm_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_AW   = $clog2(MAX_ROWS);
  localparam int COL_AW   = $clog2(MAX_COLS);
  localparam int DIM_W    = 7;

  localparam logic [1:0] REG_GRID_ROWS = 2'd0;
  localparam logic [1:0] REG_GRID_COLS = 2'd1;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_NEXT  = 1'b1;

  typedef logic [MAX_COLS-1:0] row_bits_t;

  typedef struct packed {
    logic       cmd;
    logic [5:0] cell_row;
    logic [5:0] cell_col;
    logic       cell_wall;
  } gwrm_in_t;

  typedef struct packed {
    logic       found;
    logic [5:0] rect_col;
    logic [5:0] rect_row;
    logic [6:0] rect_width;
    logic [6:0] rect_height;
  } gwrm_out_t;

  typedef struct packed {
    logic              we;
    logic [ROW_AW-1:0] waddr;
    row_bits_t         wdata;
  } ram_wr_t;

endpackage

>>> hw/rtl/gwrm_row_ram.sv
module gwrm_row_ram
  import gwrm_pkg::*;
(
  input  logic                   clk,
  input  ram_wr_t                wr,
  input  logic [ROW_AW-1:0]      raddr,
  output row_bits_t              rdata
);

  row_bits_t mem [MAX_ROWS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.waddr] <= wr.wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/grid_wall_rectangle_merger_top.sv
// Wall grid rectangle cover.
// Input beat: accepted when start is high and busy is low. cmd CMD_WRITE writes
// one wall cell (ignored outside the grid in use) and restarts the scan;
// cmd CMD_NEXT returns the next covering rectangle or a not-found result.
// Result beat: done is high for one cycle with result; the receiver cannot
// stall, so the result is simply presented. A write gives no result.
// Config: cfg_we writes grid_rows (index 0) or grid_cols (index 1) at once;
// any such write clears all claims and restarts the scan.
// A cell write reads and rewrites the wall row, then runs a claim clear pass.
// A request reads and checks each scanned cell, then per growth step reads
// and checks the next row, walks the new column row by row when it is a
// candidate, and then reads and writes each rectangle row for claiming.
// Memories are row wide with one read port; the column walk and claim pass
// dominate the run time. One item at a time; busy is high meanwhile.
// Reset: a pass over all rows clears wall and claim rows; busy is high during it.
module grid_wall_rectangle_merger_top
  import gwrm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  gwrm_in_t   item,
  output logic       done,
  output gwrm_out_t  result,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_WRD  = 4'd2;
  localparam logic [3:0] S_WWR  = 4'd3;
  localparam logic [3:0] S_SRD  = 4'd4;
  localparam logic [3:0] S_SCHK = 4'd5;
  localparam logic [3:0] S_TRD  = 4'd6;
  localparam logic [3:0] S_TCHK = 4'd7;
  localparam logic [3:0] S_RCHK = 4'd8;
  localparam logic [3:0] S_CRD  = 4'd9;
  localparam logic [3:0] S_CCHK = 4'd10;
  localparam logic [3:0] S_DEC  = 4'd11;
  localparam logic [3:0] S_LRD  = 4'd12;
  localparam logic [3:0] S_LWR  = 4'd13;

  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_ROWS);

  logic [3:0]        state;
  logic              clr_wall;
  logic [DIM_W-1:0]  rows, cols;
  logic [DIM_W-1:0]  pos_row, pos_col;
  logic [ROW_AW-1:0] x0, y0, x1, y1, cr;
  logic [COL_AW-1:0] wcol;
  logic              wbit;
  logic              diag_ok, up_ok, tok, right_ok, rok;

  row_bits_t         wall_q, claim_q, mask;
  logic [ROW_AW-1:0] raddr;
  ram_wr_t           wall_wr, claim_wr;

  logic [DIM_W-1:0]  x1p, y1p, col_next, cfg_eff;
  logic              xin, yin;

  gwrm_row_ram u_wall (.clk(clk), .wr(wall_wr), .raddr(raddr), .rdata(wall_q));
  gwrm_row_ram u_claim (.clk(clk), .wr(claim_wr), .raddr(raddr), .rdata(claim_q));

  assign x1p  = {1'b0, x1} + DIM_W'(1);
  assign y1p  = {1'b0, y1} + DIM_W'(1);
  assign xin  = x1p < cols;
  assign yin  = y1p < rows;
  assign mask = ({MAX_COLS{1'b1}} >> (COL_AW'(MAX_COLS - 1) - x1))
              & ({MAX_COLS{1'b1}} << x0);
  assign col_next = pos_col + DIM_W'(1);
  assign busy = state != S_IDLE;

  always_comb begin
    if (cfg_data == '0) cfg_eff = DIM_W'(1);
    else if (cfg_data > DIM_MAX) cfg_eff = DIM_MAX;
    else cfg_eff = cfg_data;
  end

  always_comb begin
    raddr    = cr;
    wall_wr  = '{we: 1'b0, waddr: cr, wdata: wall_q};
    claim_wr = '{we: 1'b0, waddr: cr, wdata: claim_q | mask};
    unique case (state)
      S_SRD:   raddr = pos_row[ROW_AW-1:0];
      S_TRD:   raddr = y1p[ROW_AW-1:0];
      S_TCHK:  raddr = y1;
      S_CLR: begin
        claim_wr = '{we: 1'b1, waddr: cr, wdata: '0};
        wall_wr  = '{we: clr_wall, waddr: cr, wdata: '0};
      end
      S_WWR: begin
        wall_wr.we = 1'b1;
        wall_wr.wdata[wcol] = wbit;
      end
      S_LWR:   claim_wr.we = 1'b1;
      default: raddr = cr;
    endcase
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state    <= S_CLR;
      clr_wall <= 1'b1;
      cr       <= '0;
      rows     <= DIM_MAX;
      cols     <= DIM_W'(MAX_COLS);
      pos_row  <= '0;
      pos_col  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (item.cmd == CMD_NEXT) begin
              state <= S_SRD;
            end else if ({1'b0, item.cell_row} < rows && {1'b0, item.cell_col} < cols) begin
              cr    <= item.cell_row;
              wcol  <= item.cell_col;
              wbit  <= item.cell_wall;
              state <= S_WRD;
            end
          end
        end
        S_CLR: begin
          cr <= cr + ROW_AW'(1);
          if (cr == ROW_AW'(MAX_ROWS - 1)) begin
            clr_wall <= 1'b0;
            state    <= S_IDLE;
          end
        end
        S_WRD: state <= S_WWR;
        S_WWR: begin
          cr      <= '0;
          pos_row <= '0;
          pos_col <= '0;
          state   <= S_CLR;
        end
        S_SRD: begin
          if (pos_row >= rows) begin
            done   <= 1'b1;
            result <= '0;
            state  <= S_IDLE;
          end else begin
            state <= S_SCHK;
          end
        end
        S_SCHK: begin
          if (col_next == cols) begin
            pos_col <= '0;
            pos_row <= pos_row + DIM_W'(1);
          end else begin
            pos_col <= col_next;
          end
          if (wall_q[pos_col[COL_AW-1:0]] && !claim_q[pos_col[COL_AW-1:0]]) begin
            x0    <= pos_col[COL_AW-1:0];
            x1    <= pos_col[COL_AW-1:0];
            y0    <= pos_row[ROW_AW-1:0];
            y1    <= pos_row[ROW_AW-1:0];
            state <= S_TRD;
          end else begin
            state <= S_SRD;
          end
        end
        S_TRD: state <= S_TCHK;
        S_TCHK: begin
          diag_ok <= yin && xin && wall_q[x1p[COL_AW-1:0]] && !claim_q[x1p[COL_AW-1:0]];
          up_ok   <= yin && wall_q[x1] && !claim_q[x1];
          tok     <= yin && ((wall_q & mask) == mask);
          state   <= S_RCHK;
        end
        S_RCHK: begin
          right_ok <= xin && wall_q[x1p[COL_AW-1:0]] && !claim_q[x1p[COL_AW-1:0]];
          rok      <= 1'b1;
          cr       <= y0;
          if (diag_ok || (xin && wall_q[x1p[COL_AW-1:0]] && !claim_q[x1p[COL_AW-1:0]]))
            state <= S_CRD;
          else
            state <= S_DEC;
        end
        S_CRD: state <= S_CCHK;
        S_CCHK: begin
          if (!wall_q[x1p[COL_AW-1:0]]) rok <= 1'b0;
          if (cr == y1) begin
            state <= S_DEC;
          end else begin
            cr    <= cr + ROW_AW'(1);
            state <= S_CRD;
          end
        end
        S_DEC: begin
          cr    <= y0;
          state <= S_LRD;
          priority if (diag_ok) begin
            if (tok || rok) state <= S_TRD;
            if (tok) y1 <= y1 + ROW_AW'(1);
            if (rok) x1 <= x1 + ROW_AW'(1);
          end else if (right_ok) begin
            if (rok) begin
              x1    <= x1 + ROW_AW'(1);
              state <= S_TRD;
            end
          end else if (up_ok) begin
            if (tok) begin
              y1    <= y1 + ROW_AW'(1);
              state <= S_TRD;
            end
          end
        end
        S_LRD: state <= S_LWR;
        S_LWR: begin
          if (cr == y1) begin
            done               <= 1'b1;
            result.found       <= 1'b1;
            result.rect_col    <= x0;
            result.rect_row    <= y0;
            result.rect_width  <= {1'b0, x1 - x0} + DIM_W'(1);
            result.rect_height <= {1'b0, y1 - y0} + DIM_W'(1);
            state              <= S_IDLE;
          end else begin
            cr    <= cr + ROW_AW'(1);
            state <= S_LRD;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_we && (cfg_index == REG_GRID_ROWS || cfg_index == REG_GRID_COLS)) begin
        if (cfg_index == REG_GRID_ROWS) rows <= cfg_eff;
        else cols <= cfg_eff;
        pos_row <= '0;
        pos_col <= '0;
        cr      <= '0;
        state   <= S_CLR;
      end
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while busy");
  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.cmd == CMD_NEXT && !cfg_we |=> busy)
    else $error("request not taken");
  a_found_size: assert property (@(posedge clk) disable iff (rst)
    done && result.found |-> result.rect_width != '0 && result.rect_height != '0)
    else $error("empty rectangle");
  a_nf_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.found |-> result.rect_width == '0 && result.rect_height == '0)
    else $error("not-found result not cleared");

endmodule
